[hdl/rainbow_cycle_pattern_generator_defines.svh]
`ifndef RAINBOW_CYCLE_PATTERN_GENERATOR_DEFINES_SVH
`define RAINBOW_CYCLE_PATTERN_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define RCPG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcpg assertion failed");

// Next-cycle implication, disabled in reset
`define RCPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcpg assertion failed");

`endif

[hdl/rcpg_pkg.sv]
package rcpg_pkg;

    localparam int MAX_PIXELS = 64;
    localparam int COUNT_W    = 7;
    localparam int IDX_W      = 6;
    localparam int DELAY_W    = 16;
    localparam int PHASE_W    = 11;
    localparam int POS_W      = 8;
    localparam int COL_W      = 8;
    localparam int QUO_W      = 9;
    localparam int DIV_STEPS  = 9;
    localparam int STEP_W     = 4;
    localparam int CFG_IDX_W  = 1;

    localparam logic [PHASE_W-1:0] PHASE_WRAP   = 11'd1280;
    localparam logic [COUNT_W-1:0] COUNT_RESET  = 7'd64;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 7'(MAX_PIXELS);
    localparam logic [DELAY_W-1:0] DELAY_RESET  = 16'd20;
    localparam logic [DELAY_W-1:0] ELAPSED_SAT  = 16'hFFFF;
    localparam logic [QUO_W-1:0]   WHEEL_SPAN   = 9'd256;
    localparam logic [POS_W-1:0]   SEG_ONE      = 8'd85;
    localparam logic [POS_W-1:0]   SEG_TWO      = 8'd170;
    localparam logic [COL_W-1:0]   COL_FULL     = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_DELAY = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0]   phase;
        logic [COUNT_W-1:0] count;
    } t_frame_req;

    typedef struct packed {
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [IDX_W-1:0] pixel_index;
        t_rgb             colour;
        logic             last_pixel;
    } t_pixel;

    function automatic t_rgb wheel(input logic [POS_W-1:0] p);
        t_rgb             c;
        logic [POS_W-1:0] q;
        logic [COL_W-1:0] ramp;
        if (p < SEG_ONE) begin
            q = p;
        end else if (p < SEG_TWO) begin
            q = p - SEG_ONE;
        end else begin
            q = p - SEG_TWO;
        end
        ramp = q + q + q;
        if (p < SEG_ONE) begin
            c.red   = ramp;
            c.green = COL_FULL - ramp;
            c.blue  = '0;
        end else if (p < SEG_TWO) begin
            c.red   = COL_FULL - ramp;
            c.green = '0;
            c.blue  = ramp;
        end else begin
            c.red   = '0;
            c.green = ramp;
            c.blue  = COL_FULL - ramp;
        end
        return c;
    endfunction

endpackage

[hdl/rainbow_cycle_pattern_generator.sv]
// Channel   Handshake        Payload
// ticks     push / full      i_tick
// pixels    empty / pop      o_pixel_index, o_red, o_green, o_blue, o_last_pixel
// config    i_cfg_we         i_cfg_idx, i_cfg_data
//
// A tick is taken every cycle while full is low; a tick ending a frame queues one frame request.
// Each frame starts in ST_IDLE, runs the serial 256/n divider in ST_DIVIDE, then emits one pixel a
// cycle in ST_EMIT while the output is not stalled; the next frame starts only after the last pixel.
// full rises only with two frames queued behind the one in progress; pop low stalls the pixels.
// Reset is synchronous active low and restores pixel_count 64 and frame_delay 20.
module rainbow_cycle_pattern_generator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rcpg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rcpg_pkg::DELAY_W-1:0]   i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic                           i_tick,
    output logic                           empty,
    input  logic                           pop,
    output logic [rcpg_pkg::IDX_W-1:0]     o_pixel_index,
    output logic [rcpg_pkg::COL_W-1:0]     o_red,
    output logic [rcpg_pkg::COL_W-1:0]     o_green,
    output logic [rcpg_pkg::COL_W-1:0]     o_blue,
    output logic                           o_last_pixel
);

    logic                 accept;
    logic                 fire;
    rcpg_pkg::t_frame_req front_req;
    rcpg_pkg::t_frame_req back_req;
    logic                 req_full;
    logic                 req_empty;
    logic                 req_pop;
    rcpg_pkg::t_pixel     pixel;

    assign accept = push && !req_full;
    assign full   = req_full;

    rcpg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_tick     (i_tick),
        .o_fire     (fire),
        .o_req      (front_req)
    );

    rcpg_req_fifo u_req_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_req   (front_req),
        .o_full  (req_full),
        .i_pop   (req_pop),
        .o_empty (req_empty),
        .o_req   (back_req)
    );

    rcpg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_empty (req_empty),
        .i_req       (back_req),
        .o_req_pop   (req_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_pixel     (pixel)
    );

    assign o_pixel_index = pixel.pixel_index;
    assign o_red         = pixel.colour.red;
    assign o_green       = pixel.colour.green;
    assign o_blue        = pixel.colour.blue;
    assign o_last_pixel  = pixel.last_pixel;

endmodule

[hdl/rcpg_front.sv]
module rcpg_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rcpg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rcpg_pkg::DELAY_W-1:0]   i_cfg_data,
    input  logic                           i_accept,
    input  logic                           i_tick,
    output logic                           o_fire,
    output rcpg_pkg::t_frame_req           o_req
);

    logic [rcpg_pkg::COUNT_W-1:0] r_pixel_count;
    logic [rcpg_pkg::DELAY_W-1:0] r_frame_delay;
    logic [rcpg_pkg::DELAY_W-1:0] r_elapsed, n_elapsed;
    logic [rcpg_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [rcpg_pkg::DELAY_W-1:0] elapsed_inc;
    logic [rcpg_pkg::PHASE_W-1:0] phase_inc;
    logic [rcpg_pkg::COUNT_W-1:0] count_clamped;
    logic                         fire;

    always_comb begin
        elapsed_inc = (r_elapsed == rcpg_pkg::ELAPSED_SAT) ? r_elapsed : r_elapsed + 16'd1;
        phase_inc   = r_phase + 11'd1;
        fire        = i_accept && i_tick && (elapsed_inc >= r_frame_delay);
        n_elapsed   = r_elapsed;
        n_phase     = r_phase;
        if (i_accept && i_tick) begin
            n_elapsed = fire ? '0 : elapsed_inc;
        end
        if (fire) begin
            n_phase = (phase_inc == rcpg_pkg::PHASE_WRAP) ? '0 : phase_inc;
        end
        if (r_pixel_count == '0) begin
            count_clamped = 7'd1;
        end else if (r_pixel_count > rcpg_pkg::COUNT_MAX) begin
            count_clamped = rcpg_pkg::COUNT_MAX;
        end else begin
            count_clamped = r_pixel_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_count <= rcpg_pkg::COUNT_RESET;
            r_frame_delay <= rcpg_pkg::DELAY_RESET;
            r_elapsed     <= '0;
            r_phase       <= '0;
        end else begin
            r_elapsed <= n_elapsed;
            r_phase   <= n_phase;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rcpg_pkg::CFG_PIXEL_COUNT: begin
                        r_pixel_count <= i_cfg_data[rcpg_pkg::COUNT_W-1:0];
                    end
                    rcpg_pkg::CFG_FRAME_DELAY: r_frame_delay <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_fire      = fire;
    assign o_req.phase = phase_inc[rcpg_pkg::POS_W-1:0];
    assign o_req.count = count_clamped;

endmodule

[hdl/rcpg_req_fifo.sv]
`include "rainbow_cycle_pattern_generator_defines.svh"

module rcpg_req_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  rcpg_pkg::t_frame_req i_req,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output rcpg_pkg::t_frame_req o_req
);

    rcpg_pkg::t_frame_req r_mem [2];
    logic                 r_wr_ptr;
    logic                 r_rd_ptr;
    logic [1:0]           r_count, n_count;
    logic                 do_push;
    logic                 do_pop;

    assign do_push = i_push && (r_count != 2'd2);
    assign do_pop  = i_pop && (r_count != 2'd0);

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_req   = r_mem[r_rd_ptr];

    `RCPG_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count != 2'd3)
    `RCPG_ASSERT_NOW(a_ptr_match, i_clk, i_rst_n, o_empty || o_full, r_wr_ptr == r_rd_ptr)

endmodule

[hdl/rcpg_back.sv]
`include "rainbow_cycle_pattern_generator_defines.svh"

module rcpg_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_empty,
    input  rcpg_pkg::t_frame_req i_req,
    output logic                 o_req_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output rcpg_pkg::t_pixel     o_pixel
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIVIDE = 3'b010,
        ST_EMIT   = 3'b100
    } t_state;

    t_state                        r_state, n_state;
    logic [rcpg_pkg::COUNT_W-1:0]  r_n;
    logic [rcpg_pkg::POS_W-1:0]    r_phase;
    logic [rcpg_pkg::QUO_W-1:0]    r_quo;
    logic [rcpg_pkg::POS_W-1:0]    r_rem;
    logic [rcpg_pkg::STEP_W-1:0]   r_step;
    logic [rcpg_pkg::IDX_W-1:0]    r_idx;
    logic [rcpg_pkg::POS_W-1:0]    r_acc_q;
    logic [rcpg_pkg::COUNT_W-1:0]  r_acc_r;
    logic                          r_out_valid;
    rcpg_pkg::t_pixel              r_out;

    logic [rcpg_pkg::POS_W-1:0]    trial;
    logic                          trial_ge;
    logic [rcpg_pkg::COUNT_W-1:0]  rem_sum;
    logic                          rem_wrap;
    logic                          out_free;
    logic                          emit;
    logic                          is_last;
    logic [rcpg_pkg::POS_W-1:0]    pos;

    assign trial    = {r_rem[rcpg_pkg::POS_W-2:0], r_quo[rcpg_pkg::QUO_W-1]};
    assign trial_ge = (trial >= {1'b0, r_n});
    assign rem_sum  = r_acc_r + r_rem[rcpg_pkg::COUNT_W-1:0];
    assign rem_wrap = (rem_sum >= r_n);
    assign out_free = !r_out_valid || i_pop;
    assign emit     = (r_state == ST_EMIT) && out_free;
    assign is_last  = ({1'b0, r_idx} == (r_n - 7'd1));
    assign pos      = r_acc_q + r_phase;
    assign o_req_pop = (r_state == ST_IDLE) && !i_req_empty;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_req_empty) begin
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (r_step == 4'(rcpg_pkg::DIV_STEPS - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit && is_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_n     <= i_req.count;
                r_phase <= i_req.phase;
                r_quo   <= rcpg_pkg::WHEEL_SPAN;
                r_rem   <= '0;
                r_step  <= '0;
            end
            ST_DIVIDE: begin
                r_rem   <= trial_ge ? trial - {1'b0, r_n} : trial;
                r_quo   <= {r_quo[rcpg_pkg::QUO_W-2:0], trial_ge};
                r_step  <= r_step + 4'd1;
                r_idx   <= '0;
                r_acc_q <= '0;
                r_acc_r <= '0;
            end
            ST_EMIT: begin
                if (emit) begin
                    r_idx <= r_idx + 6'd1;
                    if (rem_wrap) begin
                        r_acc_r <= rem_sum - r_n;
                        r_acc_q <= r_acc_q + r_quo[rcpg_pkg::POS_W-1:0] + 8'd1;
                    end else begin
                        r_acc_r <= rem_sum;
                        r_acc_q <= r_acc_q + r_quo[rcpg_pkg::POS_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
        if (emit) begin
            r_out.pixel_index <= r_idx;
            r_out.colour      <= rcpg_pkg::wheel(pos);
            r_out.last_pixel  <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty = !r_out_valid;
    assign o_pixel = r_out;

    `RCPG_ASSERT_NOW(a_idx_in_frame, i_clk, i_rst_n, r_state == ST_EMIT, {1'b0, r_idx} < r_n)
    `RCPG_ASSERT_NOW(a_acc_below_n, i_clk, i_rst_n, r_state == ST_EMIT, r_acc_r < r_n)
    `RCPG_ASSERT_NOW(a_rem_below_n, i_clk, i_rst_n, r_state == ST_EMIT, r_rem < {1'b0, r_n})
    `RCPG_ASSERT_NEXT(a_last_ends_frame, i_clk, i_rst_n, emit && is_last, r_out.last_pixel)

endmodule
